// ===== design/qbps_pkg.sv =====
// ----------------------------------------------------------------------------
// qbps_pkg
// Shared types, register map and datapath command codes of the quadratic
// Bezier point sampler.
// ----------------------------------------------------------------------------
package qbps_pkg;

	// Default fractional width of the curve parameter t.
	localparam int T_FRAC_BITS_DEF = 24;

	// Coordinates whose magnitude is below this many LSBs are forced to zero.
	localparam int SNAP_WINDOW = 7;

	localparam int COORD_W    = 32;
	localparam int T_STEP_W   = 25;
	localparam int MIN_DIST_W = 62;

	// Configuration port geometry: eight 64-bit registers at 8-byte spacing.
	localparam int REG_AW = 6;
	localparam int REG_DW = 64;

	localparam logic [2:0] REG_START_X  = 3'd0;
	localparam logic [2:0] REG_START_Y  = 3'd1;
	localparam logic [2:0] REG_CTRL_X   = 3'd2;
	localparam logic [2:0] REG_CTRL_Y   = 3'd3;
	localparam logic [2:0] REG_END_X    = 3'd4;
	localparam logic [2:0] REG_END_Y    = 3'd5;
	localparam logic [2:0] REG_T_STEP   = 3'd6;
	localparam logic [2:0] REG_MIN_DIST = 3'd7;

	localparam logic [T_STEP_W-1:0]   T_STEP_RST   = 25'd1678;
	localparam logic [MIN_DIST_W-1:0] MIN_DIST_RST = 62'd4295;

	// Operand pair fed to the shared multiplier.
	localparam logic [3:0] MUL_TT = 4'd0;  // t * t
	localparam logic [3:0] MUL_TW = 4'd1;  // t * (2 - t)
	localparam logic [3:0] MUL_AX = 4'd2;
	localparam logic [3:0] MUL_BX = 4'd3;
	localparam logic [3:0] MUL_CX = 4'd4;
	localparam logic [3:0] MUL_AY = 4'd5;
	localparam logic [3:0] MUL_BY = 4'd6;
	localparam logic [3:0] MUL_CY = 4'd7;
	localparam logic [3:0] MUL_DX = 4'd8;  // dx * dx
	localparam logic [3:0] MUL_DY = 4'd9;  // dy * dy

	// Accumulator operation.
	localparam logic [1:0] ACC_HOLD = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;

	// Destination of the rounded accumulator.
	localparam logic [2:0] WR_NONE = 3'd0;
	localparam logic [2:0] WR_WC   = 3'd1;
	localparam logic [2:0] WR_WD   = 3'd2;
	localparam logic [2:0] WR_PX   = 3'd3;
	localparam logic [2:0] WR_PY   = 3'd4;

	// Source loaded into the output word and the last emitted point.
	localparam logic [1:0] LD_NONE   = 2'd0;
	localparam logic [1:0] LD_START  = 2'd1;
	localparam logic [1:0] LD_END    = 2'd2;
	localparam logic [1:0] LD_SAMPLE = 2'd3;

	typedef struct packed {
		logic [COORD_W-1:0]    start_x;
		logic [COORD_W-1:0]    start_y;
		logic [COORD_W-1:0]    ctrl_x;
		logic [COORD_W-1:0]    ctrl_y;
		logic [COORD_W-1:0]    end_x;
		logic [COORD_W-1:0]    end_y;
		logic [T_STEP_W-1:0]   t_step;
		logic [MIN_DIST_W-1:0] min_dist_sq;
	} cfg_t;

	typedef struct packed {
		logic [3:0] mul_sel;
		logic [1:0] acc_op;
		logic [2:0] wr_sel;
		logic [1:0] ld_sel;
		logic       t_adv;
	} dp_cmd_t;

	typedef struct packed {
		logic t_gt_one;
		logic far;
	} dp_stat_t;

endpackage

// ===== design/qbps_regs.sv =====
// ----------------------------------------------------------------------------
// qbps_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module qbps_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [qbps_pkg::REG_AW-1:0] paddr,
	input  logic [qbps_pkg::REG_DW-1:0] pwdata,
	output logic [qbps_pkg::REG_DW-1:0] prdata,
	output logic                         pready,
	output qbps_pkg::cfg_t               cfg
);

	qbps_pkg::cfg_t cfg_q;
	logic [2:0]     idx;
	logic           wr_en;

	assign idx    = paddr[5:3];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_x     <= '0;
			cfg_q.start_y     <= '0;
			cfg_q.ctrl_x      <= '0;
			cfg_q.ctrl_y      <= '0;
			cfg_q.end_x       <= '0;
			cfg_q.end_y       <= '0;
			cfg_q.t_step      <= qbps_pkg::T_STEP_RST;
			cfg_q.min_dist_sq <= qbps_pkg::MIN_DIST_RST;
		end else if (wr_en) begin
			case (idx)
				qbps_pkg::REG_START_X:  cfg_q.start_x     <= pwdata[31:0];
				qbps_pkg::REG_START_Y:  cfg_q.start_y     <= pwdata[31:0];
				qbps_pkg::REG_CTRL_X:   cfg_q.ctrl_x      <= pwdata[31:0];
				qbps_pkg::REG_CTRL_Y:   cfg_q.ctrl_y      <= pwdata[31:0];
				qbps_pkg::REG_END_X:    cfg_q.end_x       <= pwdata[31:0];
				qbps_pkg::REG_END_Y:    cfg_q.end_y       <= pwdata[31:0];
				qbps_pkg::REG_T_STEP:   cfg_q.t_step      <= pwdata[24:0];
				qbps_pkg::REG_MIN_DIST: cfg_q.min_dist_sq <= pwdata[61:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			qbps_pkg::REG_START_X:  prdata = {32'd0, cfg_q.start_x};
			qbps_pkg::REG_START_Y:  prdata = {32'd0, cfg_q.start_y};
			qbps_pkg::REG_CTRL_X:   prdata = {32'd0, cfg_q.ctrl_x};
			qbps_pkg::REG_CTRL_Y:   prdata = {32'd0, cfg_q.ctrl_y};
			qbps_pkg::REG_END_X:    prdata = {32'd0, cfg_q.end_x};
			qbps_pkg::REG_END_Y:    prdata = {32'd0, cfg_q.end_y};
			qbps_pkg::REG_T_STEP:   prdata = {39'd0, cfg_q.t_step};
			qbps_pkg::REG_MIN_DIST: prdata = {2'd0, cfg_q.min_dist_sq};
			default:                prdata = '0;
		endcase
	end

endmodule

// ===== design/qbps_datapath.sv =====
// ----------------------------------------------------------------------------
// qbps_datapath
// Shared multiplier, accumulator and point registers; driven by commands.
// ----------------------------------------------------------------------------
module qbps_datapath #(
	parameter int T_FRAC_BITS = qbps_pkg::T_FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  qbps_pkg::cfg_t    cfg,
	input  qbps_pkg::dp_cmd_t cmd,
	output qbps_pkg::dp_stat_t stat,
	output logic [31:0]       point_x,
	output logic [31:0]       point_y,
	output logic              is_last
);

	localparam int TACC_W = ((T_FRAC_BITS > qbps_pkg::T_STEP_W) ?
		T_FRAC_BITS : qbps_pkg::T_STEP_W) + 1;
	localparam int W_W    = T_FRAC_BITS + 1;
	localparam int OPW    = (T_FRAC_BITS + 3 > 33) ? T_FRAC_BITS + 3 : 33;
	localparam int PW     = 2 * OPW;
	localparam int ACC_W  = PW + 1;

	localparam logic [TACC_W-1:0]       OneT   = TACC_W'(64'd1 << T_FRAC_BITS);
	localparam logic signed [OPW-1:0]   OneOp  = OPW'(64'd1 << T_FRAC_BITS);
	localparam logic signed [OPW-1:0]   TwoOp  = OPW'(64'd2 << T_FRAC_BITS);
	localparam logic signed [ACC_W-1:0] HalfAc = ACC_W'(64'd1 << (T_FRAC_BITS - 1));
	localparam logic signed [31:0]      SnapHi = 32'(qbps_pkg::SNAP_WINDOW);
	localparam logic signed [31:0]      SnapLo = -SnapHi;

	logic [TACC_W-1:0]       t_q;
	logic [31:0]             prev_x_q, prev_y_q;
	logic [W_W-1:0]          wc_q, wd_q;
	logic [31:0]             px_q, py_q;
	logic signed [PW-1:0]    mul_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [31:0]             pt_x_q, pt_y_q;
	logic                    last_q;

	logic signed [OPW-1:0]   op_a, op_b, t_op, a_w, b_w, c_w, dx, dy;
	logic signed [ACC_W-1:0] mul_ext, rnd_sum, rnd;
	logic signed [31:0]      blend;
	logic [31:0]             snapped;

	function automatic logic signed [OPW-1:0] sx(input logic [31:0] v);
		sx = {{(OPW - 32){v[31]}}, v};
	endfunction

	function automatic logic signed [OPW-1:0] wx(input logic [W_W-1:0] v);
		wx = {{(OPW - W_W){1'b0}}, v};
	endfunction

	// Weights: c = round(t^2), d = round(t*(2-t)), a = 1-d, b = d-c.
	assign t_op = {{(OPW - TACC_W){1'b0}}, t_q};
	assign a_w  = OneOp - wx(wd_q);
	assign b_w  = wx(wd_q) - wx(wc_q);
	assign c_w  = wx(wc_q);
	assign dx   = sx(px_q) - sx(prev_x_q);
	assign dy   = sx(py_q) - sx(prev_y_q);

	always_comb begin
		case (cmd.mul_sel)
			qbps_pkg::MUL_TT: begin op_a = t_op; op_b = t_op;         end
			qbps_pkg::MUL_TW: begin op_a = t_op; op_b = TwoOp - t_op; end
			qbps_pkg::MUL_AX: begin op_a = a_w;  op_b = sx(cfg.start_x); end
			qbps_pkg::MUL_BX: begin op_a = b_w;  op_b = sx(cfg.ctrl_x);  end
			qbps_pkg::MUL_CX: begin op_a = c_w;  op_b = sx(cfg.end_x);   end
			qbps_pkg::MUL_AY: begin op_a = a_w;  op_b = sx(cfg.start_y); end
			qbps_pkg::MUL_BY: begin op_a = b_w;  op_b = sx(cfg.ctrl_y);  end
			qbps_pkg::MUL_CY: begin op_a = c_w;  op_b = sx(cfg.end_y);   end
			qbps_pkg::MUL_DX: begin op_a = dx;   op_b = dx;           end
			qbps_pkg::MUL_DY: begin op_a = dy;   op_b = dy;           end
			default:          begin op_a = t_op; op_b = t_op;         end
		endcase
	end

	// Round half up, then floor: an arithmetic shift of the biased sum.
	assign mul_ext = {mul_q[PW-1], mul_q};
	assign rnd_sum = acc_q + HalfAc;
	assign rnd     = rnd_sum >>> T_FRAC_BITS;
	assign blend   = rnd[31:0];
	assign snapped = (blend > SnapLo && blend < SnapHi) ? 32'd0 : blend;

	always_ff @(posedge clk) begin
		mul_q <= op_a * op_b;
		case (cmd.acc_op)
			qbps_pkg::ACC_LOAD: acc_q <= mul_ext;
			qbps_pkg::ACC_ADD:  acc_q <= acc_q + mul_ext;
			default:            acc_q <= acc_q;
		endcase
		case (cmd.wr_sel)
			qbps_pkg::WR_WC: wc_q <= rnd[W_W-1:0];
			qbps_pkg::WR_WD: wd_q <= rnd[W_W-1:0];
			qbps_pkg::WR_PX: px_q <= snapped;
			qbps_pkg::WR_PY: py_q <= snapped;
			default: begin
			end
		endcase
		case (cmd.ld_sel)
			qbps_pkg::LD_START: begin
				pt_x_q <= cfg.start_x;
				pt_y_q <= cfg.start_y;
				last_q <= 1'b0;
			end
			qbps_pkg::LD_END: begin
				pt_x_q <= cfg.end_x;
				pt_y_q <= cfg.end_y;
				last_q <= 1'b1;
			end
			qbps_pkg::LD_SAMPLE: begin
				pt_x_q <= px_q;
				pt_y_q <= py_q;
				last_q <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q      <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else begin
			if (cmd.ld_sel == qbps_pkg::LD_START) begin
				t_q <= '0;
			end else if (cmd.t_adv) begin
				t_q <= t_q + TACC_W'(cfg.t_step);
			end
			case (cmd.ld_sel)
				qbps_pkg::LD_START: begin
					prev_x_q <= cfg.start_x;
					prev_y_q <= cfg.start_y;
				end
				qbps_pkg::LD_END: begin
					prev_x_q <= cfg.end_x;
					prev_y_q <= cfg.end_y;
				end
				qbps_pkg::LD_SAMPLE: begin
					prev_x_q <= px_q;
					prev_y_q <= py_q;
				end
				default: begin
				end
			endcase
		end
	end

	// The squared distance never exceeds 2^65, so comparing the unsaturated
	// sum gives the same answer as the saturated one for any 62-bit threshold.
	assign stat.t_gt_one = (t_q > OneT);
	assign stat.far      = (acc_q > $signed({{(ACC_W - qbps_pkg::MIN_DIST_W){1'b0}},
		cfg.min_dist_sq}));

	assign point_x = pt_x_q;
	assign point_y = pt_y_q;
	assign is_last = last_q;

endmodule

// ===== design/qbps_ctrl.sv =====
// ----------------------------------------------------------------------------
// qbps_ctrl
// Sequencer: accepts words, schedules the shared multiplier, owns out_valid.
// ----------------------------------------------------------------------------
module qbps_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_stall,
	input  qbps_pkg::dp_stat_t stat,
	output qbps_pkg::dp_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EVAL = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_RUN  = 2'd1;
	localparam logic [1:0] PH_DONE = 2'd2;

	localparam logic [3:0] STEP_LAST = 4'd14;

	logic [1:0] state_q, state_d;
	logic [3:0] step_q;
	logic [1:0] kind_q, kind_d;
	logic [1:0] phase_q;
	logic       out_valid_q;
	logic       in_acc, out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		kind_d      = kind_q;
		cmd.mul_sel = qbps_pkg::MUL_TT;
		cmd.acc_op  = qbps_pkg::ACC_HOLD;
		cmd.wr_sel  = qbps_pkg::WR_NONE;
		cmd.ld_sel  = qbps_pkg::LD_NONE;
		cmd.t_adv   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (restart) begin
						state_d = S_EMIT;
						kind_d  = qbps_pkg::LD_START;
					end else if (phase_q == PH_RUN) begin
						if (stat.t_gt_one) begin
							state_d = S_EMIT;
							kind_d  = qbps_pkg::LD_END;
						end else begin
							state_d = S_EVAL;
						end
					end
				end
			end
			S_EVAL: begin
				// Each product is registered in mul_q and then loaded or summed into acc_q.
				case (step_q)
					4'd0: cmd.mul_sel = qbps_pkg::MUL_TT;
					4'd1: begin
						cmd.mul_sel = qbps_pkg::MUL_TW;
						cmd.acc_op  = qbps_pkg::ACC_LOAD;
					end
					4'd2: begin
						cmd.acc_op = qbps_pkg::ACC_LOAD;
						cmd.wr_sel = qbps_pkg::WR_WC;
					end
					4'd3: cmd.wr_sel = qbps_pkg::WR_WD;
					4'd4: cmd.mul_sel = qbps_pkg::MUL_AX;
					4'd5: begin
						cmd.mul_sel = qbps_pkg::MUL_BX;
						cmd.acc_op  = qbps_pkg::ACC_LOAD;
					end
					4'd6: begin
						cmd.mul_sel = qbps_pkg::MUL_CX;
						cmd.acc_op  = qbps_pkg::ACC_ADD;
					end
					4'd7: begin
						cmd.mul_sel = qbps_pkg::MUL_AY;
						cmd.acc_op  = qbps_pkg::ACC_ADD;
					end
					4'd8: begin
						cmd.mul_sel = qbps_pkg::MUL_BY;
						cmd.acc_op  = qbps_pkg::ACC_LOAD;
						cmd.wr_sel  = qbps_pkg::WR_PX;
					end
					4'd9: begin
						cmd.mul_sel = qbps_pkg::MUL_CY;
						cmd.acc_op  = qbps_pkg::ACC_ADD;
					end
					4'd10: begin
						cmd.mul_sel = qbps_pkg::MUL_DX;
						cmd.acc_op  = qbps_pkg::ACC_ADD;
					end
					4'd11: begin
						cmd.acc_op = qbps_pkg::ACC_LOAD;
						cmd.wr_sel = qbps_pkg::WR_PY;
					end
					4'd12: cmd.mul_sel = qbps_pkg::MUL_DY;
					4'd13: cmd.acc_op = qbps_pkg::ACC_ADD;
					STEP_LAST: begin
						cmd.t_adv = 1'b1;
						if (stat.far) begin
							state_d = S_EMIT;
							kind_d  = qbps_pkg::LD_SAMPLE;
						end else begin
							state_d = S_IDLE;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.ld_sel = kind_q;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			kind_q      <= qbps_pkg::LD_NONE;
			phase_q     <= PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			if (state_q == S_EVAL) begin
				step_q <= step_q + 4'd1;
			end else begin
				step_q <= '0;
			end
			if (cmd.ld_sel == qbps_pkg::LD_START) begin
				phase_q <= PH_RUN;
			end else if (cmd.ld_sel == qbps_pkg::LD_END) begin
				phase_q <= PH_DONE;
			end
			if (cmd.ld_sel != qbps_pkg::LD_NONE) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The step counter never runs past the end of the schedule.
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |-> step_q <= STEP_LAST)
		else $error("evaluation step counter overran the schedule");

	// A pending output word is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_sel != qbps_pkg::LD_NONE |-> (!out_valid_q || !out_stall))
		else $error("output word overwritten while stalled");

	// t only advances while a curve is being sampled.
	a_adv_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.t_adv |-> phase_q == PH_RUN)
		else $error("t advanced outside the sampling phase");

	// Emitting the end point closes the curve.
	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_sel == qbps_pkg::LD_END |=> phase_q == PH_DONE && out_valid_q)
		else $error("end point emitted without closing the curve");

endmodule

// ===== design/quadratic_bezier_point_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// quadratic_bezier_point_sampler_unit
// Samples a quadratic Bezier curve from configured points, one word per tick.
// ----------------------------------------------------------------------------
// Usage: software writes start, control and end points, the t step and the
// spacing threshold over the APB-style port while the block is idle. Each
// input word is one tick: restart = 1 emits the start point and rewinds t,
// restart = 0 evaluates the curve at the current t and advances t. A sampled
// point leaves on the output channel only when its squared distance from the
// last emitted point exceeds the threshold; once t has passed one, the next
// tick emits the end point with is_last set, and later ticks emit nothing.
// A restart word or the end-point word passes through the emit state before
// the next word is accepted. An evaluation tick runs a fifteen-step schedule
// on one shared multiplier (weights, six blend products, two squared deltas)
// and, when a point is emitted, the emit state; no word is accepted until it
// is done. The output word sits in its own register, so a new input word is
// accepted while it waits. When the receiver stalls, a finished point holds
// in the sequencer until that register frees up, and in_stall stays high
// meanwhile. Reset clears the registers to their defaults, empties the
// output register and leaves the sampler idle until the first restart.
// ----------------------------------------------------------------------------
module quadratic_bezier_point_sampler_unit #(
	parameter int T_FRAC_BITS = qbps_pkg::T_FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [qbps_pkg::REG_AW-1:0] paddr,
	input  logic [qbps_pkg::REG_DW-1:0] pwdata,
	output logic [qbps_pkg::REG_DW-1:0] prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         restart,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [31:0]                  point_x,
	output logic [31:0]                  point_y,
	output logic                         is_last
);

	qbps_pkg::cfg_t     cfg;
	qbps_pkg::dp_cmd_t  cmd;
	qbps_pkg::dp_stat_t stat;

	// Configuration registers; writes take effect at the access phase.
	qbps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer: handshakes, curve phase and the multiplier schedule.
	qbps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.restart   (restart),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Arithmetic: t accumulator, weights, blend, snap, distance and the
	// output word register.
	qbps_datapath #(
		.T_FRAC_BITS (T_FRAC_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cmd     (cmd),
		.stat    (stat),
		.point_x (point_x),
		.point_y (point_y),
		.is_last (is_last)
	);

endmodule
